[sv/ilist_pkg.sv]
package ilist_pkg;

  // Default list size
  localparam int DEF_CAPACITY = 64;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  // Memory write address and data source
  typedef enum logic [1:0] {
    WSEL_END,
    WSEL_POS,
    WSEL_SHIFT
  } wsel_t;

  // Memory read address source
  typedef enum logic {
    RSEL_POS,
    RSEL_PTR
  } rsel_t;

  // Entry count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_ZERO
  } cnt_op_t;

  // Result word source
  typedef enum logic [1:0] {
    OSEL_ZERO,
    OSEL_ONES,
    OSEL_RDATA
  } osel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              load_in;
    logic              wr_en;
    wsel_t             wr_sel;
    logic              rd_en;
    rsel_t             rd_sel;
    cnt_op_t           cnt_op;
    logic              ptr_load;
    logic              ptr_dec;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    osel_t             out_sel;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             pos_ok;
    logic             full;
    logic             empty;
    logic             shift_last;
    logic             out_free;
  } dp_stat_t;

endpackage

[sv/ilist_dp.sv]
module ilist_dp #(
  parameter int CAPACITY = ilist_pkg::DEF_CAPACITY
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic        [ilist_pkg::CMD_W-1:0]     in_command,
  input  logic        [ilist_pkg::POS_W-1:0]     in_position,
  input  logic signed [ilist_pkg::WORD_W-1:0]    in_word_in,
  input  logic                                   out_stall,
  input  ilist_pkg::dp_cmd_t                     cmd,
  output ilist_pkg::dp_stat_t                    stat,
  output logic                                   out_valid,
  output logic signed [ilist_pkg::WORD_W-1:0]    out_word_out,
  output logic        [ilist_pkg::STAT_W-1:0]    out_status,
  output logic        [ilist_pkg::FILL_W-1:0]    out_fill_count
);
  import ilist_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int FW   = (CW < FILL_W) ? CW : FILL_W;

  logic [WORD_W-1:0] mem [CAPACITY];

  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] rdata_r;
  logic [AW-1:0]     ptr_r;
  logic [AW-1:0]     ptr_nxt;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_word_r;
  logic [STAT_W-1:0] out_status_r;
  logic [FILL_W-1:0] out_fill_r;
  logic [AW-1:0]     pos_idx;
  logic [AW-1:0]     ptr_dn;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] out_word_nxt;

  assign pos_idx = AW'(pos_r);
  assign ptr_dn  = AW'(ptr_r - 1'b1);

  // Report status to the controller
  assign stat.cmd        = cmd_r;
  assign stat.pos_ok     = CMPW'(pos_r) < CMPW'(cnt_r);
  assign stat.full       = (cnt_r == CW'(CAPACITY));
  assign stat.empty      = (cnt_r == '0);
  assign stat.shift_last = (ptr_dn == pos_idx);
  assign stat.out_free   = !out_valid_r || !out_stall;

  // Select memory write address and data
  always_comb begin
    wr_addr = AW'(cnt_r);
    wr_data = word_r;
    case (cmd.wr_sel)
      WSEL_END: begin
        wr_addr = AW'(cnt_r);
        wr_data = word_r;
      end
      WSEL_POS: begin
        wr_addr = pos_idx;
        wr_data = word_r;
      end
      WSEL_SHIFT: begin
        wr_addr = ptr_r;
        wr_data = rdata_r;
      end
      default: begin
        wr_addr = AW'(cnt_r);
        wr_data = word_r;
      end
    endcase
  end

  assign rd_addr = (cmd.rd_sel == RSEL_PTR) ? ptr_dn : pos_idx;

  // Update the entry count
  always_comb begin
    case (cmd.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_INC:  cnt_nxt = CW'(cnt_r + 1'b1);
      CNT_DEC:  cnt_nxt = CW'(cnt_r - 1'b1);
      CNT_ZERO: cnt_nxt = '0;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  // Advance the shift pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_load) begin
      ptr_nxt = AW'(cnt_r);
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_dn;
    end
  end

  // Select the result word
  always_comb begin
    case (cmd.out_sel)
      OSEL_ZERO:  out_word_nxt = '0;
      OSEL_ONES:  out_word_nxt = '1;
      OSEL_RDATA: out_word_nxt = rdata_r;
      default:    out_word_nxt = '0;
    endcase
  end

  // Hold the result until the receiver takes it
  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load_in) begin
      cmd_r  <= in_command;
      pos_r  <= in_position;
      word_r <= in_word_in;
    end
    if (cmd.out_load) begin
      out_word_r   <= out_word_nxt;
      out_status_r <= cmd.out_status;
      out_fill_r   <= FILL_W'(cnt_nxt[FW-1:0]);
    end
  end

  // Entry memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_out   = out_word_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transaction");

  a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.wr_sel == WSEL_SHIFT) |-> (ptr_r > pos_idx))
    else $error("shift write at or below insert position");

  a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_fill_r == FILL_W'(cnt_r[FW-1:0])))
    else $error("reported fill count differs from entry count");
`endif

endmodule

[sv/ilist_ctrl.sv]
module ilist_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ilist_pkg::dp_stat_t stat,
  output logic                in_stall,
  output ilist_pkg::dp_cmd_t  cmd
);
  import ilist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET_WAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Decode the command and sequence the insert shift
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.wr_sel     = WSEL_END;
    cmd.rd_sel     = RSEL_POS;
    cmd.cnt_op     = CNT_HOLD;
    cmd.out_status = ST_OK;
    cmd.out_sel    = OSEL_ZERO;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
          case (stat.cmd)
            CMD_APPEND: begin
              cmd.out_load = 1'b1;
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WSEL_END;
                cmd.cnt_op = CNT_INC;
              end
            end
            CMD_INSERT: begin
              if (!stat.pos_ok) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_INDEX;
              end else if (stat.full) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_FULL;
              end else begin
                cmd.ptr_load = 1'b1;
                state_nxt    = S_SHIFT_RD;
              end
            end
            CMD_POP: begin
              cmd.out_load = 1'b1;
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.cnt_op = CNT_DEC;
              end
            end
            CMD_GET: begin
              if (!stat.pos_ok) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_INDEX;
                cmd.out_sel    = OSEL_ONES;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RSEL_POS;
                state_nxt  = S_GET_WAIT;
              end
            end
            CMD_SET: begin
              cmd.out_load = 1'b1;
              if (!stat.pos_ok) begin
                cmd.out_status = ST_INDEX;
              end else begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WSEL_POS;
              end
            end
            CMD_CLEAR: begin
              cmd.out_load = 1'b1;
              cmd.cnt_op   = CNT_ZERO;
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      S_GET_WAIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_RDATA;
          state_nxt    = S_IDLE;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RSEL_PTR;
        state_nxt  = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WSEL_SHIFT;
        cmd.ptr_dec = 1'b1;
        state_nxt   = stat.shift_last ? S_INS_WR : S_SHIFT_RD;
      end
      S_INS_WR: begin
        if (stat.out_free) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WSEL_POS;
          cmd.cnt_op   = CNT_INC;
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op != CNT_HOLD) |-> cmd.out_load)
    else $error("entry count changed without a result");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted transaction not decoded");
`endif

endmodule

[sv/indexed_list_with_insert_shift.sv]
// Ordered list of signed 32-bit words held in one memory of CAPACITY entries.
// Input channel (in_valid/in_stall): in_command, in_position, in_word_in.
// Commands: append, insert at position, pop, get, set, clear.
// Result channel (out_valid/out_stall): out_word_out, out_status,
// out_fill_count; exactly one result transaction per input transaction.
// A successful get waits for the registered memory read before its result is
// loaded. A successful insert first moves each entry at or above the position
// up by one, with one read and one write on the single port pair per entry.
// One transaction is worked on at a time; the next is accepted in the cycle
// after the previous result is loaded.
// The result register parts the channels: a new transaction is accepted while
// a result waits, and a result that cannot be loaded because the receiver
// stalls holds the block in its final step with the entry count unchanged.
// Reset empties the list and drops any pending result. Stored words are
// undefined until written.
module indexed_list_with_insert_shift #(
  parameter int CAPACITY = ilist_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [ilist_pkg::CMD_W-1:0]  in_command,
  input  logic        [ilist_pkg::POS_W-1:0]  in_position,
  input  logic signed [ilist_pkg::WORD_W-1:0] in_word_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ilist_pkg::WORD_W-1:0] out_word_out,
  output logic        [ilist_pkg::STAT_W-1:0] out_status,
  output logic        [ilist_pkg::FILL_W-1:0] out_fill_count
);
  import ilist_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence commands
  ilist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Hold entries, count and result
  ilist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_word_in     (in_word_in),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_word_out   (out_word_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ilist_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 140;

  // Codes left unused by the command set
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Stimulus mix
  localparam int MODE_GROW = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED = 2;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [STAT_W-1:0]        status;
    logic [FILL_W-1:0]        fill;
  } list_result_t;

  // Track list contents and the results they imply
  class list_scoreboard;
    logic signed [WORD_W-1:0] words [CAPACITY];
    int unsigned              count;
    list_result_t             pending [$];
    int                       errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic signed [WORD_W-1:0] word);
      list_result_t res;
      res.word = '0;
      res.status = ST_OK;
      case (cmd)
        CMD_APPEND: begin
          if (count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            words[count] = word;
            count++;
          end
        end
        CMD_INSERT: begin
          if (pos >= count) begin
            res.status = ST_INDEX;
          end else if (count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (int i = count; i > pos; i--) words[i] = words[i-1];
            words[pos] = word;
            count++;
          end
        end
        CMD_POP: begin
          if (count == 0) res.status = ST_EMPTY;
          else count--;
        end
        CMD_GET: begin
          if (pos >= count) begin
            res.status = ST_INDEX;
            res.word = '1;
          end else begin
            res.word = words[pos];
          end
        end
        CMD_SET: begin
          if (pos >= count) res.status = ST_INDEX;
          else words[pos] = word;
        end
        CMD_CLEAR: count = 0;
        default: ;
      endcase
      res.fill = FILL_W'(count);
      pending.push_back(res);
    endfunction

    function void check_result(logic signed [WORD_W-1:0] word, logic [STAT_W-1:0] status,
                               logic [FILL_W-1:0] fill);
      list_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: word_out %0d status %0d fill_count %0d",
               word, status, fill);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (word !== want.word) begin
        $error("word_out: expected %0d, got %0d", want.word, word);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (fill !== want.fill) begin
        $error("fill_count: expected %0d, got %0d", want.fill, fill);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command = CMD_APPEND;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [WORD_W-1:0] in_word_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] out_word_out;
  logic [STAT_W-1:0]        out_status;
  logic [FILL_W-1:0]        out_fill_count;

  list_scoreboard sb;
  int unsigned    idle_pct = 0;
  int             quiet_cycles = 0;

  // Command weights per mix: append, insert, pop, get, set, clear, spare
  int mix_weights [3][7] = '{
    '{40, 30, 5, 12, 10, 1, 2},
    '{8, 7, 45, 20, 15, 3, 2},
    '{22, 22, 18, 18, 15, 2, 3}
  };
  logic [CMD_W-1:0] mix_codes [7] = '{
    CMD_APPEND, CMD_INSERT, CMD_POP, CMD_GET, CMD_SET, CMD_CLEAR, CMD_SPARE_LO
  };

  indexed_list_with_insert_shift #(.CAPACITY(CAPACITY)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_position   (in_position),
    .in_word_in    (in_word_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word_out  (out_word_out),
    .out_status    (out_status),
    .out_fill_count(out_fill_count)
  );

  always #5 clk = ~clk;

  // Present one command, optionally after a gap, and hold it until taken
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic signed [WORD_W-1:0] word);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_position <= pos;
    in_word_in <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(cmd, pos, word);
  endtask

  // Draw one random command shaped by the current mix and list fill
  task automatic send_random(input int mode);
    int                       pick;
    int                       idx;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
    pick = $urandom_range(0, 99);
    idx = 0;
    while (idx < 6 && pick >= mix_weights[mode][idx]) begin
      pick -= mix_weights[mode][idx];
      idx++;
    end
    cmd = mix_codes[idx];
    if (cmd == CMD_SPARE_LO && $urandom_range(0, 1) == 1) cmd = CMD_SPARE_HI;
    if (sb.count > 0 && $urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(0, sb.count - 1));
    else pos = POS_W'($urandom_range(0, CAPACITY - 1));
    case ($urandom_range(0, 15))
      0: word = 32'sh8000_0000;
      1: word = 32'sh7fff_ffff;
      2: word = '0;
      3: word = '1;
      default: word = $urandom;
    endcase
    send_command(cmd, pos, word);
  endtask

  // Check each result taken by the block's receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_word_out, out_status, out_fill_count);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stall the result channel in random bursts
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Reset, directed checks, random phases, drain
  initial begin
    int mode;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-list errors, extreme words, inserts at head and middle
    idle_pct = 20;
    send_command(CMD_GET, 6'd0, '0);
    send_command(CMD_POP, 6'd0, '0);
    send_command(CMD_INSERT, 6'd0, 32'sh1111_1111);
    send_command(CMD_SET, 6'd0, 32'sh2222_2222);
    send_command(CMD_APPEND, 6'd0, 32'sh8000_0000);
    send_command(CMD_APPEND, 6'd63, 32'sh7fff_ffff);
    send_command(CMD_INSERT, 6'd0, '0);
    send_command(CMD_INSERT, 6'd1, '1);
    for (int i = 0; i < 4; i++) send_command(CMD_GET, POS_W'(i), '0);
    send_command(CMD_SET, 6'd3, 32'sh5555_aaaa);
    send_command(CMD_GET, 6'd3, '0);
    send_command(CMD_GET, 6'd63, '0);
    send_command(CMD_SET, 6'd63, 32'sh3333_3333);
    send_command(CMD_INSERT, 6'd4, 32'sh4444_4444);
    send_command(CMD_SPARE_LO, 6'd2, 32'sh6666_6666);
    send_command(CMD_SPARE_HI, 6'd63, '1);
    send_command(CMD_CLEAR, 6'd0, '0);
    send_command(CMD_GET, 6'd0, '0);
    send_command(CMD_POP, 6'd0, '0);
    send_command(CMD_APPEND, 6'd0, 32'sh1234_5678);
    send_command(CMD_GET, 6'd0, '0);

    // Random phases; the first and fourth use the growing mix, the last runs without gaps
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 30;
        default: idle_pct = 60;
      endcase
      if (ph == RANDOM_PHASES - 1) idle_pct = 0;
      if (ph == 0 || ph == 3) mode = MODE_GROW;
      else mode = $urandom_range(MODE_GROW, MODE_MIXED);
      repeat (PHASE_ITEMS) send_random(mode);
    end

    // Drain outstanding results
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[indexed_list_with_insert_shift.f]
sv/ilist_pkg.sv
sv/ilist_dp.sv
sv/ilist_ctrl.sv
sv/indexed_list_with_insert_shift.sv
tb/testbench.sv
